FILE: rtl/wildcard_pattern_matcher_core_macros.svh
// ============================================================================
// Wildcard pattern matcher assertion macros
// Shared concurrent assertion forms for the wildcard pattern matcher RTL.
// ============================================================================
`ifndef WILDCARD_PATTERN_MATCHER_CORE_MACROS_SVH
`define WILDCARD_PATTERN_MATCHER_CORE_MACROS_SVH

// Clocked property, disabled while reset is high.
`define WPM_ASSERT_PROP(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define WPM_ASSERT_NEVER(name, clk, rst, cond, msg) \
   `WPM_ASSERT_PROP(name, clk, rst, !(cond), msg)

`endif

FILE: rtl/wpm_pkg.sv
// ============================================================================
// Wildcard pattern matcher package
// Shared constants, register indexes and types for the matcher blocks.
// ============================================================================
package wpm_pkg;

   // Pattern storage is four 64-bit words of eight characters each.
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int PAT_WORDS   = 4;
   localparam int PAT_BITS    = PAT_WORDS * CSR_DATA_W;
   localparam int LEN_W       = 6;

   // Wildcard characters.
   localparam logic [7:0] STAR_CHAR = 8'h2A;
   localparam logic [7:0] ANY_CHAR  = 8'h3F;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_WORD_0 = 3'd0,
      CSR_PATTERN_WORD_1 = 3'd1,
      CSR_PATTERN_WORD_2 = 3'd2,
      CSR_PATTERN_WORD_3 = 3'd3,
      CSR_PATTERN_LENGTH = 3'd4
   } csr_index_type;

   // Programmed pattern as seen by the datapath.
   typedef struct packed {
      logic [PAT_BITS-1:0] chars;
      logic [LEN_W-1:0]    length;
   } pattern_type;

   // Character idx of the pattern, character 0 in the lowest byte.
   function automatic logic [7:0] pat_char(input logic [PAT_BITS-1:0] chars, input int idx);
      return chars[idx*8 +: 8];
   endfunction

endpackage

FILE: rtl/wildcard_pattern_matcher_core.sv
// A byte taken into the input stage moves into the result register once that register frees.
// Throughput: one byte per cycle while the result register is not stalled; the prefix row update is combinational.
// A stalled result register holds while the input stage still takes a byte if it is empty.
// Reset (synchronous, active high) clears the pattern, empties both stages and
// sets the prefix row to bit zero alone.
// ============================================================================
// Wildcard pattern matcher
// Streams subject bytes and reports whether the glob pattern ('*', '?')
// matches the subject read so far.
// ============================================================================
`include "wildcard_pattern_matcher_core_macros.svh"

module wildcard_pattern_matcher_core
   import wpm_pkg::*;
#(
   parameter int PATTERN_MAX = 32
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_subject_char,
   input  logic                   req_starts_subject,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_matched,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int ROW_W = PATTERN_MAX + 1;

   pattern_type      pattern;
   logic             s1_valid_ff;
   logic             s1_valid_in;
   logic [7:0]       s1_char_ff;
   logic             s1_start_ff;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             rsp_matched_ff;
   logic             advance;
   logic             req_transfer;
   logic [ROW_W-1:0] prev_row;
   logic [ROW_W-1:0] next_row;
   logic             step_matched;

   wpm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pattern          (pattern)
   );

   // Handshake: the result register frees when empty or taken.
   assign advance      = !rsp_valid_ff || rsp_ready;
   assign req_ready    = !s1_valid_ff || advance;
   assign req_transfer = req_valid && req_ready;

   // A new subject restarts from the empty prefix.
   assign prev_row = s1_start_ff ? ROW_W'(1) : row_ff;

   wpm_row_update #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_row_update (
      .pattern      (pattern),
      .subject_char (s1_char_ff),
      .prev_row     (prev_row),
      .next_row     (next_row),
      .matched      (step_matched)
   );

   // Next state of the control flops.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      row_in       = row_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
         if (s1_valid_ff) begin
            row_in = next_row;
         end
      end
      if (req_transfer) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_ff       <= ROW_W'(1);
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         row_ff       <= row_in;
      end
   end

   // Payload registers of the input stage and the result stage.
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         s1_char_ff  <= req_subject_char;
         s1_start_ff <= req_starts_subject;
      end
      if (advance && s1_valid_ff) begin
         rsp_matched_ff <= step_matched;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

   // Once a byte has been consumed the empty prefix can no longer match.
   `WPM_ASSERT_PROP(a_row_zero_cleared, clock, reset, (s1_valid_ff && advance) |=> !row_ff[0], "prefix row bit zero still set after a byte")
   // A held input byte is never dropped while the result stage is blocked.
   `WPM_ASSERT_PROP(a_s1_held, clock, reset, (s1_valid_ff && !advance) |=> s1_valid_ff, "input stage lost a byte while stalled")
   // A result only appears after a byte sat in the input stage.
   `WPM_ASSERT_PROP(a_rsp_from_s1, clock, reset, $rose(rsp_valid_ff) |-> $past(s1_valid_ff), "result appeared without a byte in the input stage")
   // An empty pattern never reports a match.
   `WPM_ASSERT_NEVER(a_empty_no_match, clock, reset, rsp_valid_ff && rsp_matched_ff && (pattern.length == '0), "match reported for an empty pattern")

endmodule

FILE: rtl/wpm_csr.sv
// ============================================================================
// Wildcard pattern matcher configuration registers
// Holds the pattern words and the pattern length written over the CSR port.
// ============================================================================
module wpm_csr
   import wpm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output pattern_type            pattern
);

   logic [CSR_DATA_W-1:0] words_ff [PAT_WORDS];
   logic [CSR_DATA_W-1:0] words_in [PAT_WORDS];
   logic [LEN_W-1:0]      length_ff;
   logic [LEN_W-1:0]      length_in;

   // Decode a write; indexes past the register list are dropped.
   always_comb begin
      for (int i = 0; i < PAT_WORDS; i++) begin
         words_in[i] = words_ff[i];
      end
      length_in = length_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PATTERN_WORD_0: words_in[0] = csr_write_data;
            CSR_PATTERN_WORD_1: words_in[1] = csr_write_data;
            CSR_PATTERN_WORD_2: words_in[2] = csr_write_data;
            CSR_PATTERN_WORD_3: words_in[3] = csr_write_data;
            CSR_PATTERN_LENGTH: length_in = csr_write_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAT_WORDS; i++) begin
            words_ff[i] <= '0;
         end
         length_ff <= '0;
      end else begin
         for (int i = 0; i < PAT_WORDS; i++) begin
            words_ff[i] <= words_in[i];
         end
         length_ff <= length_in;
      end
   end

   // Flatten the words, character 0 lowest.
   always_comb begin
      for (int i = 0; i < PAT_WORDS; i++) begin
         pattern.chars[i*CSR_DATA_W +: CSR_DATA_W] = words_ff[i];
      end
      pattern.length = length_ff;
   end

endmodule

FILE: rtl/wpm_row_update.sv
// ============================================================================
// Wildcard pattern matcher row update
// Computes the next prefix match row and the match flag for one subject byte.
// ============================================================================
module wpm_row_update
   import wpm_pkg::*;
#(
   parameter int PATTERN_MAX = 32
)
(
   input  pattern_type            pattern,
   input  logic [7:0]             subject_char,
   input  logic [PATTERN_MAX:0]   prev_row,
   output logic [PATTERN_MAX:0]   next_row,
   output logic                   matched
);

   localparam int ROW_W       = PATTERN_MAX + 1;
   localparam int IDX_W       = $clog2(ROW_W);
   localparam int SPAN_STAGES = $clog2(ROW_W);

   // Parallel prefix over runs of stars: a set bit carries upward through
   // every position whose preceding pattern character is a star.
   function automatic logic [ROW_W-1:0] star_span(input logic [ROW_W-1:0] gen,
                                                   input logic [ROW_W-1:0] prop);
      logic [ROW_W-1:0] g;
      logic [ROW_W-1:0] p;
      g = gen;
      p = prop;
      for (int s = 0; s < SPAN_STAGES; s++) begin
         g = g | (p & (g << (1 << s)));
         p = p & (p << (1 << s));
      end
      return g;
   endfunction

   logic [IDX_W-1:0] len_active;
   logic [ROW_W-1:0] star_mask;
   logic [ROW_W-1:0] len_mask;
   logic [ROW_W-1:0] closed_row;
   logic [ROW_W-1:0] step_gen;
   logic [ROW_W-1:0] step_row;

   // Clamp the programmed length to the row size.
   always_comb begin
      if (pattern.length > LEN_W'(PATTERN_MAX)) begin
         len_active = IDX_W'(PATTERN_MAX);
      end else begin
         len_active = pattern.length[IDX_W-1:0];
      end
   end

   // Star positions and the active row bits.
   always_comb begin
      star_mask = '0;
      len_mask  = '0;
      for (int j = 1; j <= PATTERN_MAX; j++) begin
         star_mask[j] = (pat_char(pattern.chars, j - 1) == STAR_CHAR);
         len_mask[j]  = (IDX_W'(j) <= len_active);
      end
   end

   // Let stars match an empty run in the old row.
   assign closed_row = star_span(prev_row, star_mask);

   // Per-position step on the subject byte.
   always_comb begin
      step_gen = '0;
      for (int j = 1; j <= PATTERN_MAX; j++) begin
         if (star_mask[j]) begin
            step_gen[j] = closed_row[j] | closed_row[j-1];
         end else if (pat_char(pattern.chars, j - 1) == ANY_CHAR) begin
            step_gen[j] = closed_row[j-1];
         end else begin
            step_gen[j] = closed_row[j-1] &
                          (pat_char(pattern.chars, j - 1) == subject_char);
         end
      end
   end

   // A star also extends a match made at the position below it.
   assign step_row = star_span(step_gen, star_mask);
   assign next_row = step_row & len_mask;
   assign matched  = (len_active != '0) && next_row[len_active];

endmodule
